>>> design/snsgd_pkg.sv
package snsgd_pkg;

  // Fixed-point format and sigmoid table geometry.
  localparam int FRAC_BITS   = 12;
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

  // Field widths.
  localparam int LR_W       = 13;
  localparam int DATA_W     = 16;
  localparam int TARGET_W   = 13;
  localparam int PRED_W     = 13;
  localparam int LOSS_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BIAS   = CFG_IDX_W'(2);

  // Register values after reset.
  localparam logic [LR_W-1:0]          LR_RESET          = LR_W'(614);
  localparam logic signed [DATA_W-1:0] INIT_WEIGHT_RESET = DATA_W'(2458);
  localparam logic signed [DATA_W-1:0] INIT_BIAS_RESET   = DATA_W'(3686);

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] sample;
    logic [TARGET_W-1:0]      target;
  } in_item_t;

  typedef struct packed {
    logic [PRED_W-1:0]        prediction;
    logic [LOSS_W-1:0]        loss;
    logic signed [DATA_W-1:0] weight_now;
    logic signed [DATA_W-1:0] bias_now;
  } out_item_t;

  // Microcode fields.
  typedef enum logic [2:0] {
    MA_ZERO, MA_X, MA_ERR, MA_A, MA_ALPHA, MA_D
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_ZERO, MB_W, MB_ERR, MB_NOT_A, MB_SP, MB_D, MB_X, MB_T
  } mul_b_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_Z, DST_A, DST_LOSS, DST_SP, DST_D, DST_BIAS, DST_T, DST_WEIGHT
  } dst_e;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_WAIT_IN, JMP_IF_PREDICT, JMP_EMIT
  } jmp_e;

  typedef struct packed {
    mul_a_e ma;
    mul_b_e mb;
    logic   rnd_wide;
    dst_e   dst;
    jmp_e   jmp;
  } ucode_t;

  // Unsigned long division by shift and subtract, used while the sigmoid
  // table is built. The divisor stays far below 2^63.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
      rem = {rem[62:0], num[bit_pos]};
      if (rem >= dvs) begin
        rem          = rem - dvs;
        quo[bit_pos] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One sigmoid entry: exp by a Taylor series over t/16, squared four times,
  // then a rounded reciprocal. Negative arguments use 1 - sigmoid(-z).
  function automatic logic [PRED_W-1:0] sig_entry(input int unsigned i);
    longint          m2;
    logic            neg;
    longint unsigned t;
    longint unsigned u;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned e;
    longint unsigned den;
    longint unsigned pos;
    longint          res;
    m2  = 2 * longint'(i) - longint'(SIG_ENTRIES);
    neg = (m2 < 0);
    if (neg) begin
      m2 = -m2;
    end
    t    = $unsigned(8 * m2) << 30;
    t    = t / SIG_ENTRIES;
    u    = (t + 64'd8) >> 4;
    term = 64'd1 << 30;
    acc  = term;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * u) >> 30, $unsigned(longint'(k)));
      if (k[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    e = acc;
    for (int j = 0; j < 4; j++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    den = (64'd1 << 30) + e;
    pos = udiv64((64'd1 << (FRAC_BITS + 30)) + (den >> 1), den);
    if (neg) begin
      res = (longint'(1) << FRAC_BITS) - longint'(pos);
    end else begin
      res = longint'(pos);
    end
    return PRED_W'(res);
  endfunction

  typedef logic [PRED_W-1:0] sig_table_t [SIG_ENTRIES];

  function automatic sig_table_t sig_table_build();
    sig_table_t tbl;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      tbl[i] = sig_entry($unsigned(i));
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = sig_table_build();

endpackage

>>> design/single_neuron_sgd_step_unit.sv
// Single sigmoid neuron with an on-line gradient descent step, Q4.12 fixed point.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one item carries an
// operation bit, a sample x and a target y. The block takes one item at a time;
// in_stall_o is high from the cycle after an item is taken until its result has
// been moved into the output register, and for one cycle after reset while the
// weight and bias are loaded from the initial_weight and initial_bias registers.
// Output channel (out_valid_o / out_stall_i / out_data_o): one item per input
// item with the prediction, the half squared error and the weight and bias as
// they stand after the item. The output register holds a finished item while
// the receiver stalls, and the next input item is taken and worked on meanwhile.
// The work is done by a microcode sequencer driving one shared 18x18 multiplier,
// at most one multiply per step: a predict-only item runs the steps Z, LUT and
// LOSS, a training item also SP, D, GB, T and GW, and each then waits in the
// EMIT step until the output register is free to take its result.
// Configuration port (cfg_valid_i / cfg_ready_o): always ready; index 0 is the
// learning rate, 1 and 2 the initial weight and bias, which are only loaded
// after reset, and reset also restores them. Other indexes are ignored. Reset
// restores all three registers and empties the output register.
module single_neuron_sgd_step_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  snsgd_pkg::in_item_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output snsgd_pkg::out_item_t                 out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [snsgd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [snsgd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int F        = snsgd_pkg::FRAC_BITS;
  localparam int DATA_W   = snsgd_pkg::DATA_W;
  localparam int LR_W     = snsgd_pkg::LR_W;
  localparam int PRED_W   = snsgd_pkg::PRED_W;
  localparam int TARGET_W = snsgd_pkg::TARGET_W;
  localparam int LOSS_W   = snsgd_pkg::LOSS_W;
  localparam int IDX_W    = snsgd_pkg::SIG_IDX_W;

  // Internal widths, sized to the value ranges of each quantity.
  localparam int MUL_W   = 18;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ERR_W   = 15;
  localparam int Z_W     = 20;
  localparam int ZOFF_W  = Z_W + 1;
  localparam int SCALE_W = ZOFF_W + IDX_W + 1;
  localparam int SP_W    = 12;
  localparam int D_W     = 13;
  localparam int T_W     = 16;
  localparam int SUB_W   = 20;
  localparam int STEP_W  = 4;

  localparam logic signed [PROD_W-1:0] HALF_NARROW = PROD_W'(1) << (F - 1);
  localparam logic signed [PROD_W-1:0] HALF_WIDE   = PROD_W'(1) << F;
  localparam logic signed [PROD_W-1:0] LOSS_MAX    = PROD_W'((1 << LOSS_W) - 1);
  localparam logic signed [ERR_W-1:0]  ONE         = ERR_W'(1 << F);
  localparam logic signed [ZOFF_W-1:0] Z_OFFSET    = ZOFF_W'(8 << F);
  localparam logic signed [SUB_W-1:0]  SAT_HI      = SUB_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [SUB_W-1:0]  SAT_LO      = -SUB_W'(1 << (DATA_W - 1));

  // Microprogram step addresses.
  localparam logic [STEP_W-1:0] ST_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_Z      = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_LUT    = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_LOSS   = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_SP     = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_D      = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_GB     = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_T      = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_GW     = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_EMIT   = STEP_W'(9);

  // The control store. Each step names the two multiplier operands, the
  // rounding shift, the register that takes the result and the branch.
  function automatic snsgd_pkg::ucode_t ucode_rom(input logic [STEP_W-1:0] s);
    snsgd_pkg::ucode_t uc;
    uc.ma       = snsgd_pkg::MA_ZERO;
    uc.mb       = snsgd_pkg::MB_ZERO;
    uc.rnd_wide = 1'b0;
    uc.dst      = snsgd_pkg::DST_NONE;
    uc.jmp      = snsgd_pkg::JMP_NEXT;
    case (s)
      ST_IDLE: begin
        uc.jmp = snsgd_pkg::JMP_WAIT_IN;
      end
      ST_Z: begin
        uc.ma  = snsgd_pkg::MA_X;
        uc.mb  = snsgd_pkg::MB_W;
        uc.dst = snsgd_pkg::DST_Z;
      end
      ST_LUT: begin
        uc.dst = snsgd_pkg::DST_A;
      end
      ST_LOSS: begin
        uc.ma       = snsgd_pkg::MA_ERR;
        uc.mb       = snsgd_pkg::MB_ERR;
        uc.rnd_wide = 1'b1;
        uc.dst      = snsgd_pkg::DST_LOSS;
        uc.jmp      = snsgd_pkg::JMP_IF_PREDICT;
      end
      ST_SP: begin
        uc.ma  = snsgd_pkg::MA_A;
        uc.mb  = snsgd_pkg::MB_NOT_A;
        uc.dst = snsgd_pkg::DST_SP;
      end
      ST_D: begin
        uc.ma  = snsgd_pkg::MA_ERR;
        uc.mb  = snsgd_pkg::MB_SP;
        uc.dst = snsgd_pkg::DST_D;
      end
      ST_GB: begin
        uc.ma  = snsgd_pkg::MA_ALPHA;
        uc.mb  = snsgd_pkg::MB_D;
        uc.dst = snsgd_pkg::DST_BIAS;
      end
      ST_T: begin
        uc.ma  = snsgd_pkg::MA_D;
        uc.mb  = snsgd_pkg::MB_X;
        uc.dst = snsgd_pkg::DST_T;
      end
      ST_GW: begin
        uc.ma  = snsgd_pkg::MA_ALPHA;
        uc.mb  = snsgd_pkg::MB_T;
        uc.dst = snsgd_pkg::DST_WEIGHT;
      end
      ST_EMIT: begin
        uc.jmp = snsgd_pkg::JMP_EMIT;
      end
      default: begin
        uc.jmp = snsgd_pkg::JMP_NEXT;
      end
    endcase
    return uc;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUB_W-1:0] v);
    logic signed [SUB_W-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return c[DATA_W-1:0];
  endfunction

  // Control and configuration registers.
  logic [STEP_W-1:0]          step_q, step_d;
  logic                       reload_q;
  logic                       out_valid_q, out_valid_d;
  logic [LR_W-1:0]            lr_q;
  logic signed [DATA_W-1:0]   init_w_q;
  logic signed [DATA_W-1:0]   init_b_q;

  // Datapath registers.
  logic                       op_q;
  logic signed [DATA_W-1:0]   x_q;
  logic [TARGET_W-1:0]        y_q;
  logic signed [DATA_W-1:0]   w_q, w_d;
  logic signed [DATA_W-1:0]   b_q, b_d;
  logic signed [Z_W-1:0]      z_q, z_d;
  logic [PRED_W-1:0]          a_q, a_d;
  logic [LOSS_W-1:0]          loss_q, loss_d;
  logic signed [SP_W-1:0]     sp_q, sp_d;
  logic signed [D_W-1:0]      d_q, d_d;
  logic signed [T_W-1:0]      t_q, t_d;
  snsgd_pkg::out_item_t       out_q, out_d;

  snsgd_pkg::ucode_t          uc;
  logic                       in_accept;
  logic                       out_load;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    not_a;
  logic signed [MUL_W-1:0]    opa, opb;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   res;
  logic signed [ZOFF_W-1:0]   zoff;
  logic [SCALE_W-1:0]         idx_prod;
  logic [SCALE_W-1:0]         idx_scaled;
  logic [IDX_W-1:0]           idx;
  logic signed [SUB_W-1:0]    w_diff, b_diff;

  assign uc          = ucode_rom(step_q);
  assign in_stall_o  = (step_q != ST_IDLE) || reload_q;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (uc.jmp == snsgd_pkg::JMP_EMIT) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Error and one minus the prediction, both feeding the multiplier.
  assign err   = $signed(ERR_W'(a_q)) - $signed(ERR_W'(y_q));
  assign not_a = ONE - $signed(ERR_W'(a_q));

  always_comb begin
    case (uc.ma)
      snsgd_pkg::MA_X:     opa = MUL_W'(x_q);
      snsgd_pkg::MA_ERR:   opa = MUL_W'(err);
      snsgd_pkg::MA_A:     opa = $signed(MUL_W'(a_q));
      snsgd_pkg::MA_ALPHA: opa = $signed(MUL_W'(lr_q));
      snsgd_pkg::MA_D:     opa = MUL_W'(d_q);
      default:             opa = '0;
    endcase
    case (uc.mb)
      snsgd_pkg::MB_W:     opb = MUL_W'(w_q);
      snsgd_pkg::MB_ERR:   opb = MUL_W'(err);
      snsgd_pkg::MB_NOT_A: opb = MUL_W'(not_a);
      snsgd_pkg::MB_SP:    opb = MUL_W'(sp_q);
      snsgd_pkg::MB_D:     opb = MUL_W'(d_q);
      snsgd_pkg::MB_X:     opb = MUL_W'(x_q);
      snsgd_pkg::MB_T:     opb = MUL_W'(t_q);
      default:             opb = '0;
    endcase
  end

  // Shared multiplier with round-half-up back to the fraction width; the
  // loss step drops one more bit for the division by two.
  assign prod = opa * opb;
  assign res  = uc.rnd_wide ? ((prod + HALF_WIDE) >>> (F + 1))
                            : ((prod + HALF_NARROW) >>> F);

  // Table index: floor((z + 8) * entries / 16), clamped at both ends.
  assign zoff       = ZOFF_W'(z_q) + Z_OFFSET;
  assign idx_prod   = SCALE_W'(zoff[ZOFF_W-2:0]) * SCALE_W'(snsgd_pkg::SIG_ENTRIES);
  assign idx_scaled = idx_prod >> (F + 4);

  always_comb begin
    if (zoff[ZOFF_W-1]) begin
      idx = '0;
    end else if (idx_scaled >= SCALE_W'(snsgd_pkg::SIG_ENTRIES)) begin
      idx = IDX_W'(snsgd_pkg::SIG_ENTRIES - 1);
    end else begin
      idx = idx_scaled[IDX_W-1:0];
    end
  end

  assign w_diff = SUB_W'(w_q) - $signed(res[SUB_W-1:0]);
  assign b_diff = SUB_W'(b_q) - $signed(res[SUB_W-1:0]);

  // Result write-back, selected by the destination field.
  always_comb begin
    z_d    = z_q;
    a_d    = a_q;
    loss_d = loss_q;
    sp_d   = sp_q;
    d_d    = d_q;
    t_d    = t_q;
    w_d    = w_q;
    b_d    = b_q;
    if (reload_q) begin
      w_d = init_w_q;
      b_d = init_b_q;
    end
    case (uc.dst)
      snsgd_pkg::DST_Z:      z_d    = $signed(res[Z_W-1:0]) + Z_W'(b_q);
      snsgd_pkg::DST_A:      a_d    = snsgd_pkg::SIG_TABLE[idx];
      snsgd_pkg::DST_LOSS:   loss_d = (res > LOSS_MAX) ? '1 : res[LOSS_W-1:0];
      snsgd_pkg::DST_SP:     sp_d   = $signed(res[SP_W-1:0]);
      snsgd_pkg::DST_D:      d_d    = $signed(res[D_W-1:0]);
      snsgd_pkg::DST_BIAS:   b_d    = sat_data(b_diff);
      snsgd_pkg::DST_T:      t_d    = $signed(res[T_W-1:0]);
      snsgd_pkg::DST_WEIGHT: w_d    = sat_data(w_diff);
      default: begin
      end
    endcase
  end

  // Sequencer: step counter with the branch selected by the control word.
  always_comb begin
    step_d = step_q;
    case (uc.jmp)
      snsgd_pkg::JMP_WAIT_IN: begin
        if (in_accept) begin
          step_d = ST_Z;
        end
      end
      snsgd_pkg::JMP_IF_PREDICT: begin
        step_d = op_q ? (step_q + STEP_W'(1)) : ST_EMIT;
      end
      snsgd_pkg::JMP_EMIT: begin
        if (out_load) begin
          step_d = ST_IDLE;
        end
      end
      default: begin
        step_d = step_q + STEP_W'(1);
      end
    endcase
  end

  // Output register: loaded at the end of the program, emptied when taken.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_d.prediction = a_q;
      out_d.loss       = loss_q;
      out_d.weight_now = w_q;
      out_d.bias_now   = b_q;
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      reload_q    <= 1'b1;
      out_valid_q <= 1'b0;
      lr_q        <= snsgd_pkg::LR_RESET;
      init_w_q    <= snsgd_pkg::INIT_WEIGHT_RESET;
      init_b_q    <= snsgd_pkg::INIT_BIAS_RESET;
    end else begin
      step_q      <= step_d;
      reload_q    <= 1'b0;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          snsgd_pkg::CFG_LEARNING_RATE:  lr_q     <= cfg_data_i[LR_W-1:0];
          snsgd_pkg::CFG_INITIAL_WEIGHT: init_w_q <= $signed(cfg_data_i[DATA_W-1:0]);
          snsgd_pkg::CFG_INITIAL_BIAS:   init_b_q <= $signed(cfg_data_i[DATA_W-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= in_data_i.operation;
      x_q  <= in_data_i.sample;
      y_q  <= in_data_i.target;
    end
    z_q    <= z_d;
    a_q    <= a_d;
    loss_q <= loss_d;
    sp_q   <= sp_d;
    d_q    <= d_d;
    t_q    <= t_d;
    w_q    <= w_d;
    b_q    <= b_d;
    out_q  <= out_d;
  end

endmodule

>>> design/snsgd_checker.sv
module snsgd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input snsgd_pkg::out_item_t out_data_o
);

  // A result waiting on a stalled receiver stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A result waiting on a stalled receiver does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output item changed while stalled");

  // Items are worked on one at a time, so the block is busy after a take.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an item");

  // A new result only appears at the end of an item's work.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

endmodule

bind single_neuron_sgd_step_unit snsgd_checker u_snsgd_checker (.*);
